@@ hw/rtl/tsm_pkg.sv @@
// Shared codes and field widths for the two-way sorted merge core.
`default_nettype none

package tsm_pkg;

    // Width of the key and payload fields on both channels.
    localparam int FIELD_W = 32;

    // Input item kinds, carried on the slave tuser.
    localparam int KIND_W = 2;
    localparam logic [KIND_W-1:0] KIND_APPEND_A = 2'd0;
    localparam logic [KIND_W-1:0] KIND_APPEND_B = 2'd1;
    localparam logic [KIND_W-1:0] KIND_MERGE    = 2'd2;

    // Result flags, carried on the master tuser, lowest bit first.
    localparam int OUT_USER_W = 3;
    localparam int UB_FROM    = 0;
    localparam int UB_EMPTY   = 1;
    localparam int UB_OVF     = 2;

    // Status of one result held in the output register.
    typedef struct packed {
        logic from_list;
        logic last_pair;
        logic empty_run;
        logic overflowed;
    } t_out_flags;

endpackage

`default_nettype wire

@@ hw/rtl/two_way_sorted_merge_core.sv @@
// Two-way sorted merge core: list storage, merge sequencer and output register.
//
// Usage:
//   Slave channel (i_s_axis_*) takes items. tuser carries the kind: append to
//   the first list, append to the second list, or run a merge. tdata carries
//   the key in bits [31:0] and the payload in bits [63:32]; both are ignored
//   on a merge. Appends beyond DEPTH are dropped and set a sticky overflow flag.
//   Master channel (o_m_axis_*) returns the merged pairs in ascending signed
//   key order, first list ahead on equal keys; tlast marks the final pair.
//   A merge of two empty lists returns one item flagged empty_run.
// Timing:
//   An append is taken while the sequencer is idle. A merge first enters
//   S_FETCH, then each pair passes S_FETCH for the registered read of both
//   list heads and S_EMIT for the shared signed compare that picks the head
//   and loads the output register; S_EMIT waits while the receiver stalls.
//   An empty merge passes S_EMPTY, which loads its result. tready is low from
//   the merge until its last pair is loaded into the output register.
// Reset (synchronous, active low) empties both lists, clears the overflow
//   flag and drops any result not yet taken. List contents are not cleared.
// Stall: while tready is low the output register holds its item and the
//   sequencer waits; no pair is lost or repeated.
`default_nettype none

module two_way_sorted_merge_core
    import tsm_pkg::*;
#(
    parameter int DEPTH      = 32,
    parameter int DATA_WIDTH = 32
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,

    input  wire logic                   i_s_axis_tvalid,
    output logic                        o_s_axis_tready,
    input  wire logic [2*FIELD_W-1:0]   i_s_axis_tdata,  // key, payload
    input  wire logic [KIND_W-1:0]      i_s_axis_tuser,  // kind

    output logic                        o_m_axis_tvalid,
    input  wire logic                   i_m_axis_tready,
    output logic [2*FIELD_W-1:0]        o_m_axis_tdata,  // merged_key, merged_payload
    output logic                        o_m_axis_tlast,  // last_pair
    output logic [OUT_USER_W-1:0]       o_m_axis_tuser   // from_list, empty_run, overflowed
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [CW-1:0] FULL = CW'(DEPTH);

    // Sequencer states
    localparam int ST_W = 2;
    localparam logic [ST_W-1:0] S_IDLE  = 2'd0;
    localparam logic [ST_W-1:0] S_FETCH = 2'd1;
    localparam logic [ST_W-1:0] S_EMIT  = 2'd2;
    localparam logic [ST_W-1:0] S_EMPTY = 2'd3;

    logic [ST_W-1:0] r_state, n_state;
    logic [CW-1:0]   r_cnt_a, r_cnt_b;
    logic [CW-1:0]   r_i, r_j;
    logic            r_ovf;

    // List storage
    logic [DATA_WIDTH-1:0] r_mem_a_key [DEPTH];
    logic [DATA_WIDTH-1:0] r_mem_a_pay [DEPTH];
    logic [DATA_WIDTH-1:0] r_mem_b_key [DEPTH];
    logic [DATA_WIDTH-1:0] r_mem_b_pay [DEPTH];

    // Registered head reads
    logic [DATA_WIDTH-1:0] r_a_key, r_a_pay, r_b_key, r_b_pay;

    // Output register
    logic                  r_out_valid;
    logic [FIELD_W-1:0]    r_out_key, r_out_pay;
    t_out_flags            r_out_flags;

    logic                  in_fire;
    logic [63:0]           key_ext, pay_ext;
    logic [DATA_WIDTH-1:0] st_key, st_pay;
    logic                  out_free;
    logic                  a_done, b_done, key_le, take_a, is_last;
    logic                  emit, emit_empty;
    logic [DATA_WIDTH-1:0] sel_key, sel_pay;
    logic [63:0]           sel_key_ext, sel_pay_ext;

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign in_fire         = i_s_axis_tvalid && o_s_axis_tready;

    // Sign-extend the 32-bit fields, then keep the stored width.
    assign key_ext = 64'($signed(i_s_axis_tdata[FIELD_W-1:0]));
    assign pay_ext = 64'($signed(i_s_axis_tdata[2*FIELD_W-1:FIELD_W]));
    assign st_key  = key_ext[DATA_WIDTH-1:0];
    assign st_pay  = pay_ext[DATA_WIDTH-1:0];

    assign out_free = !r_out_valid || i_m_axis_tready;

    // Head selection: the one shared signed compare of the merge.
    assign a_done  = (r_i == r_cnt_a);
    assign b_done  = (r_j == r_cnt_b);
    assign key_le  = $signed(r_a_key) <= $signed(r_b_key);
    assign take_a  = !a_done && (b_done || key_le);
    assign is_last = take_a ? ((r_i + CW'(1) == r_cnt_a) && b_done)
                            : ((r_j + CW'(1) == r_cnt_b) && a_done);

    assign emit       = (r_state == S_EMIT) && out_free;
    assign emit_empty = (r_state == S_EMPTY) && out_free;

    assign sel_key     = take_a ? r_a_key : r_b_key;
    assign sel_pay     = take_a ? r_a_pay : r_b_pay;
    assign sel_key_ext = 64'($signed(sel_key));
    assign sel_pay_ext = 64'($signed(sel_pay));

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_fire && i_s_axis_tuser == KIND_MERGE) begin
                    if (r_cnt_a == '0 && r_cnt_b == '0) begin
                        n_state = S_EMPTY;
                    end else begin
                        n_state = S_FETCH;
                    end
                end
            end
            S_FETCH: begin
                n_state = S_EMIT;
            end
            S_EMIT: begin
                if (emit) begin
                    n_state = is_last ? S_IDLE : S_FETCH;
                end
            end
            S_EMPTY: begin
                if (emit_empty) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control state: counts, head indices, overflow flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt_a <= '0;
            r_cnt_b <= '0;
            r_i     <= '0;
            r_j     <= '0;
            r_ovf   <= 1'b0;
        end else begin
            r_state <= n_state;
            if (in_fire) begin
                unique case (i_s_axis_tuser)
                    KIND_APPEND_A: begin
                        if (r_cnt_a < FULL) begin
                            r_cnt_a <= r_cnt_a + CW'(1);
                        end else begin
                            r_ovf <= 1'b1;
                        end
                    end
                    KIND_APPEND_B: begin
                        if (r_cnt_b < FULL) begin
                            r_cnt_b <= r_cnt_b + CW'(1);
                        end else begin
                            r_ovf <= 1'b1;
                        end
                    end
                    default: begin
                        // merge starts through the sequencer; unused kind is dropped
                    end
                endcase
            end
            if (emit) begin
                if (is_last) begin
                    // clear both lists and the flag once the run is out
                    r_cnt_a <= '0;
                    r_cnt_b <= '0;
                    r_i     <= '0;
                    r_j     <= '0;
                    r_ovf   <= 1'b0;
                end else if (take_a) begin
                    r_i <= r_i + CW'(1);
                end else begin
                    r_j <= r_j + CW'(1);
                end
            end
            if (emit_empty) begin
                r_ovf <= 1'b0;
            end
        end
    end

    // List writes
    always_ff @(posedge i_clk) begin
        if (in_fire && i_s_axis_tuser == KIND_APPEND_A && r_cnt_a < FULL) begin
            r_mem_a_key[r_cnt_a[AW-1:0]] <= st_key;
            r_mem_a_pay[r_cnt_a[AW-1:0]] <= st_pay;
        end
        if (in_fire && i_s_axis_tuser == KIND_APPEND_B && r_cnt_b < FULL) begin
            r_mem_b_key[r_cnt_b[AW-1:0]] <= st_key;
            r_mem_b_pay[r_cnt_b[AW-1:0]] <= st_pay;
        end
    end

    // Head reads; data for the current indices is ready in the next cycle.
    always_ff @(posedge i_clk) begin
        r_a_key <= r_mem_a_key[r_i[AW-1:0]];
        r_a_pay <= r_mem_a_pay[r_i[AW-1:0]];
        r_b_key <= r_mem_b_key[r_j[AW-1:0]];
        r_b_pay <= r_mem_b_pay[r_j[AW-1:0]];
    end

    // Output register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (emit || emit_empty) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Output register payload
    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out_key              <= sel_key_ext[FIELD_W-1:0];
            r_out_pay              <= sel_pay_ext[FIELD_W-1:0];
            r_out_flags.from_list  <= !take_a;
            r_out_flags.last_pair  <= is_last;
            r_out_flags.empty_run  <= 1'b0;
            r_out_flags.overflowed <= r_ovf;
        end else if (emit_empty) begin
            r_out_key              <= '0;
            r_out_pay              <= '0;
            r_out_flags.from_list  <= 1'b0;
            r_out_flags.last_pair  <= 1'b1;
            r_out_flags.empty_run  <= 1'b1;
            r_out_flags.overflowed <= 1'b0;
        end
    end

    assign o_m_axis_tvalid          = r_out_valid;
    assign o_m_axis_tdata           = {r_out_pay, r_out_key};
    assign o_m_axis_tlast           = r_out_flags.last_pair;
    assign o_m_axis_tuser[UB_FROM]  = r_out_flags.from_list;
    assign o_m_axis_tuser[UB_EMPTY] = r_out_flags.empty_run;
    assign o_m_axis_tuser[UB_OVF]   = r_out_flags.overflowed;

    // Head indices never run past their list counts.
    a_idx_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_i <= r_cnt_a) && (r_j <= r_cnt_b) && (r_cnt_a <= FULL) && (r_cnt_b <= FULL))
        else $error("head index or count out of range");

    // A final pair leaves both lists and the flag cleared.
    a_last_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (emit && is_last) |=> (r_cnt_a == '0 && r_cnt_b == '0 && !r_ovf
                               && o_m_axis_tvalid && o_m_axis_tlast))
        else $error("merge end did not clear lists");

    // A full first list drops the append and raises the flag.
    a_full_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_fire && i_s_axis_tuser == KIND_APPEND_A && r_cnt_a == FULL)
        |=> (r_ovf && r_cnt_a == FULL))
        else $error("append to full list not dropped");

    // An empty run result is the last one and carries zero data.
    a_empty_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tuser[UB_EMPTY])
        |-> (o_m_axis_tlast && o_m_axis_tdata == '0 && !o_m_axis_tuser[UB_OVF]))
        else $error("malformed empty run result");

    // Input stays blocked while a merge is in progress.
    a_busy_block: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_fire && i_s_axis_tuser == KIND_MERGE) |=> !o_s_axis_tready)
        else $error("input taken during merge");

endmodule

`default_nettype wire

@@ verif/merge_order_checker.sv @@
// Checker that predicts the merged pair order and compares every result item.
`timescale 1ns / 100ps

module merge_order_checker
    import tsm_pkg::*;
#(
    parameter int DEPTH      = 32,
    parameter int DATA_WIDTH = 32
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,

    input  wire logic                   i_s_tvalid,
    input  wire logic                   i_s_tready,
    input  wire logic [2*FIELD_W-1:0]   i_s_tdata,   // key, payload
    input  wire logic [KIND_W-1:0]      i_s_tuser,   // kind

    input  wire logic                   i_m_tvalid,
    input  wire logic                   i_m_tready,
    input  wire logic [2*FIELD_W-1:0]   i_m_tdata,   // merged_key, merged_payload
    input  wire logic                   i_m_tlast,   // last_pair
    input  wire logic [OUT_USER_W-1:0]  i_m_tuser,   // from_list, empty_run, overflowed

    output int                          o_errors,
    output int                          o_pending,
    output int                          o_results,
    output int                          o_merges,
    output int                          o_overflow_merges
);

    typedef logic signed [FIELD_W-1:0] t_word;

    typedef struct packed {
        t_word key;
        t_word payload;
        logic  from_list;
        logic  last_pair;
        logic  empty_run;
        logic  overflowed;
    } t_merged_pair;

    t_word        list_key [2][DEPTH];
    t_word        list_pay [2][DEPTH];
    int           list_len [2];
    logic         drop_seen;
    t_merged_pair pairs_due[$];
    int           mismatch_count       = 0;
    int           result_count         = 0;
    int           merge_count          = 0;
    int           overflow_merge_count = 0;
    int           pending_count        = 0;

    assign o_errors          = mismatch_count;
    assign o_pending         = pending_count;
    assign o_results         = result_count;
    assign o_merges          = merge_count;
    assign o_overflow_merges = overflow_merge_count;

    // Keep the low DATA_WIDTH bits and sign-extend them back to the field width.
    function automatic t_word to_stored(input logic [FIELD_W-1:0] v);
        if (DATA_WIDTH >= FIELD_W)
            return t_word'(v);
        return t_word'($signed(v << (FIELD_W - DATA_WIDTH)) >>> (FIELD_W - DATA_WIDTH));
    endfunction

    // Walk both lists, smaller head first, first list on a tie; then clear.
    function automatic void predict_merge_run();
        int           ia;
        int           ib;
        int           total;
        logic         take_first;
        t_merged_pair r;
        ia    = 0;
        ib    = 0;
        total = list_len[0] + list_len[1];
        merge_count++;
        if (total == 0) begin
            r           = '0;
            r.last_pair = 1'b1;
            r.empty_run = 1'b1;
            pairs_due.push_back(r);
        end else begin
            if (drop_seen)
                overflow_merge_count++;
            while (ia + ib < total) begin
                if (ia >= list_len[0])
                    take_first = 1'b0;
                else if (ib >= list_len[1])
                    take_first = 1'b1;
                else
                    take_first = (list_key[0][ia] <= list_key[1][ib]);
                r            = '0;
                r.from_list  = !take_first;
                r.overflowed = drop_seen;
                if (take_first) begin
                    r.key     = list_key[0][ia];
                    r.payload = list_pay[0][ia];
                    ia++;
                end else begin
                    r.key     = list_key[1][ib];
                    r.payload = list_pay[1][ib];
                    ib++;
                end
                r.last_pair = (ia + ib == total);
                pairs_due.push_back(r);
            end
        end
        list_len[0] = 0;
        list_len[1] = 0;
        drop_seen   = 1'b0;
    endfunction

    function automatic void take_item(input logic [KIND_W-1:0] kind,
                                      input logic [2*FIELD_W-1:0] data);
        int idx;
        idx = (kind == KIND_APPEND_B) ? 1 : 0;
        case (kind) inside
            KIND_APPEND_A, KIND_APPEND_B: begin
                if (list_len[idx] < DEPTH) begin
                    list_key[idx][list_len[idx]] = to_stored(data[FIELD_W-1:0]);
                    list_pay[idx][list_len[idx]] = to_stored(data[2*FIELD_W-1:FIELD_W]);
                    list_len[idx]++;
                end else begin
                    // list full: drop the pair, remember it for the next merge
                    drop_seen = 1'b1;
                end
            end
            KIND_MERGE: predict_merge_run();
            default: ;  // unused kind changes nothing
        endcase
    endfunction

    function automatic void check_result(input t_merged_pair got);
        t_merged_pair want;
        result_count++;
        if (pairs_due.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
                $display("%0t: unexpected result key=%0d payload=%0d from=%0b %s",
                         $realtime, got.key, got.payload, got.from_list,
                         $sformatf("last=%0b empty=%0b ovf=%0b",
                                   got.last_pair, got.empty_run, got.overflowed));
            return;
        end
        want = pairs_due.pop_front();
        if (got.key !== want.key || got.payload !== want.payload
                || got.from_list !== want.from_list || got.last_pair !== want.last_pair
                || got.empty_run !== want.empty_run || got.overflowed !== want.overflowed) begin
            mismatch_count++;
            if (mismatch_count <= 10) begin
                $display("%0t: result mismatch", $realtime);
                $display("    expected key=%0d payload=%0d from=%0b last=%0b empty=%0b ovf=%0b",
                         want.key, want.payload, want.from_list, want.last_pair,
                         want.empty_run, want.overflowed);
                $display("    actual   key=%0d payload=%0d from=%0b last=%0b empty=%0b ovf=%0b",
                         got.key, got.payload, got.from_list, got.last_pair,
                         got.empty_run, got.overflowed);
            end
        end
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            list_len[0] = 0;
            list_len[1] = 0;
            drop_seen   = 1'b0;
            pairs_due.delete();
        end else begin
            // compare first: a result leaving now never stems from an item taken now
            if (i_m_tvalid && i_m_tready)
                check_result('{key:        i_m_tdata[FIELD_W-1:0],
                               payload:    i_m_tdata[2*FIELD_W-1:FIELD_W],
                               from_list:  i_m_tuser[UB_FROM],
                               last_pair:  i_m_tlast,
                               empty_run:  i_m_tuser[UB_EMPTY],
                               overflowed: i_m_tuser[UB_OVF]});
            if (i_s_tvalid && i_s_tready)
                take_item(i_s_tuser, i_s_tdata);
        end
        pending_count <= pairs_due.size();
    end

endmodule

@@ verif/tb_two_way_sorted_merge_core.sv @@
// Testbench top for the two-way sorted merge core: stimulus, flow control and verdict.
`timescale 1ns / 100ps

module tb_two_way_sorted_merge_core
    import tsm_pkg::*;
();

    localparam int                LIST_DEPTH     = 32;
    localparam int                STORE_W        = 32;
    localparam logic [KIND_W-1:0] KIND_UNUSED    = 2'd3;
    localparam int                RANDOM_ITEMS   = 145;
    // Longest quiet stretch: a choked receiver plus a sender gap stays far below this.
    localparam int                WATCHDOG_LIMIT = 2000;
    // An empty merge answers from the S_EMPTY state; leave ample margin.
    localparam int                DRAIN_CYCLES   = 16;

    typedef enum logic [1:0] {KEYS_WIDE, KEYS_TIGHT, KEYS_EDGE} t_key_style;
    typedef enum logic [1:0] {RX_STREAM, RX_COIN, RX_MOSTLY, RX_CHOKE} t_rx_mode;

    logic                  i_clk    = 1'b0;
    logic                  i_rst_n  = 1'b0;

    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [2*FIELD_W-1:0]  s_tdata  = '0;   // key, payload
    logic [KIND_W-1:0]     s_tuser  = '0;   // kind

    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [2*FIELD_W-1:0]  m_tdata;         // merged_key, merged_payload
    logic                  m_tlast;         // last_pair
    logic [OUT_USER_W-1:0] m_tuser;         // from_list, empty_run, overflowed

    int       errors;
    int       pending;
    int       results;
    int       merges;
    int       overflow_merges;
    int       burst_left   = 0;
    int       idle_cycles  = 0;
    int       random_items = 0;
    t_rx_mode rx_mode      = RX_STREAM;
    int       rx_left      = 0;

    // 20 ns period
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    two_way_sorted_merge_core #(
        .DEPTH      (LIST_DEPTH),
        .DATA_WIDTH (STORE_W)
    ) DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .o_m_axis_tlast  (m_tlast),
        .o_m_axis_tuser  (m_tuser)
    );

    merge_order_checker #(
        .DEPTH      (LIST_DEPTH),
        .DATA_WIDTH (STORE_W)
    ) u_checker (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_s_tvalid        (s_tvalid),
        .i_s_tready        (s_tready),
        .i_s_tdata         (s_tdata),
        .i_s_tuser         (s_tuser),
        .i_m_tvalid        (m_tvalid),
        .i_m_tready        (m_tready),
        .i_m_tdata         (m_tdata),
        .i_m_tlast         (m_tlast),
        .i_m_tuser         (m_tuser),
        .o_errors          (errors),
        .o_pending         (pending),
        .o_results         (results),
        .o_merges          (merges),
        .o_overflow_merges (overflow_merges)
    );

    // Receiver: switch between stall modes at random, from a steady
    // stream through coin flips to a nearly choked channel.
    always @(posedge i_clk) begin
        if (rx_left == 0) begin
            rx_mode <= t_rx_mode'($urandom_range(0, 3));
            rx_left <= $urandom_range(4, 40);
        end else begin
            rx_left <= rx_left - 1;
        end
        case (rx_mode)
            RX_STREAM: m_tready <= 1'b1;
            RX_COIN:   m_tready <= 1'($urandom_range(0, 1));
            RX_MOSTLY: m_tready <= ($urandom_range(0, 7) != 0);
            default:   m_tready <= ($urandom_range(0, 5) == 0);
        endcase
    end

    // Watchdog: end the run once neither channel has moved an item for too long.
    always @(posedge i_clk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Watchdog: no item moved for %0d cycles", WATCHDOG_LIMIT);
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Offer one item and hold it until the core takes it. Between bursts, drop
    // valid for a random gap; a zero gap keeps valid high across the boundary.
    task automatic send_item(input logic [KIND_W-1:0] kind,
                             input logic [FIELD_W-1:0] key,
                             input logic [FIELD_W-1:0] payload);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 16);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {payload, key};
        s_tuser  <= kind;
        do
            @(posedge i_clk);
        while (!s_tready);
        burst_left--;
    endtask

    function automatic int pick_key(input t_key_style style);
        case (style)
            // narrow range: ties inside and across the lists
            KEYS_TIGHT: return int'($urandom_range(0, 6)) - 3;
            KEYS_EDGE: begin
                case ($urandom_range(0, 4))
                    0:       return int'(32'h8000_0000);
                    1:       return int'(32'h7FFF_FFFF);
                    2:       return -1;
                    3:       return 0;
                    default: return int'($urandom());
                endcase
            end
            default: return int'($urandom());
        endcase
    endfunction

    // Load both lists, interleaving the two at random with stray unused-kind
    // items mixed in, then ask for the merge. Unsorted lists show up when
    // keep_order is clear.
    task automatic load_and_merge(input int n_a, input int n_b,
                                  input t_key_style style, input bit keep_order);
        int keys_a[$];
        int keys_b[$];
        int ia;
        int ib;
        bit pick_a;
        ia = 0;
        ib = 0;
        repeat (n_a) keys_a.push_back(pick_key(style));
        repeat (n_b) keys_b.push_back(pick_key(style));
        if (keep_order) begin
            keys_a.sort();
            keys_b.sort();
        end
        while (ia < n_a || ib < n_b) begin
            if ($urandom_range(0, 9) == 0)
                send_item(KIND_UNUSED, $urandom(), $urandom());
            pick_a = (ib >= n_b) || (ia < n_a && $urandom_range(0, 1) == 1);
            if (pick_a) begin
                send_item(KIND_APPEND_A, keys_a[ia], $urandom());
                ia++;
            end else begin
                send_item(KIND_APPEND_B, keys_b[ib], $urandom());
                ib++;
            end
        end
        // key and payload are don't-care on a merge: fill them with noise
        send_item(KIND_MERGE, $urandom(), $urandom());
    endtask

    initial begin
        int         n_a;
        int         n_b;
        int         swap_tmp;
        t_key_style style;

        // Hold reset at the start, then release it for good.
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Merge with both lists empty: one item flagged empty, fields ignored.
        send_item(KIND_MERGE, 32'hFFFF_FFFF, 32'h8000_0000);
        // Unused kind with all ones must leave the lists alone.
        send_item(KIND_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_item(KIND_MERGE, 32'h0000_0000, 32'h0000_0000);

        // First list only, key and payload extremes.
        send_item(KIND_APPEND_A, 32'h8000_0000, 32'h7FFF_FFFF);
        send_item(KIND_APPEND_A, 32'h7FFF_FFFF, 32'h8000_0000);
        send_item(KIND_MERGE, 32'h1234_5678, 32'h9ABC_DEF0);

        // Second list only.
        send_item(KIND_APPEND_B, 32'hFFFF_FFFF, 32'h0000_0000);
        send_item(KIND_APPEND_B, 32'h0000_0000, 32'hFFFF_FFFF);
        send_item(KIND_MERGE, 32'h0, 32'h0);

        // Equal keys across the lists, including at the top of the range:
        // the first list must win every tie.
        send_item(KIND_APPEND_A, -5, 1);
        send_item(KIND_APPEND_B, -5, 2);
        send_item(KIND_APPEND_A, 3, 3);
        send_item(KIND_APPEND_B, 3, 4);
        send_item(KIND_APPEND_A, 3, 5);
        send_item(KIND_APPEND_B, 7, 6);
        send_item(KIND_APPEND_A, 32'h7FFF_FFFF, 7);
        send_item(KIND_APPEND_B, 32'h7FFF_FFFF, 8);
        send_item(KIND_MERGE, 32'h0, 32'h0);

        // Unsorted lists: merge still takes the smaller head each step.
        send_item(KIND_APPEND_A, 10, 11);
        send_item(KIND_APPEND_A, 2, 12);
        send_item(KIND_APPEND_B, 5, 13);
        send_item(KIND_MERGE, 32'h0, 32'h0);

        // Overfill both lists up front so dropped loads and the longest
        // merge appear early.
        load_and_merge(LIST_DEPTH + 1, LIST_DEPTH + 2, KEYS_WIDE, 1'b1);
        random_items = 2 * LIST_DEPTH + 4;

        // Mostly short sorted runs, now and then one list near or past capacity.
        while (random_items < RANDOM_ITEMS) begin
            if ($urandom_range(0, 14) == 0) begin
                n_a = $urandom_range(LIST_DEPTH - 2, LIST_DEPTH + 2);
                n_b = $urandom_range(0, 4);
                if ($urandom_range(0, 1) == 1) begin
                    swap_tmp = n_a;
                    n_a      = n_b;
                    n_b      = swap_tmp;
                end
            end else begin
                n_a = $urandom_range(0, 6);
                n_b = $urandom_range(0, 6);
            end
            style = t_key_style'($urandom_range(0, 2));
            load_and_merge(n_a, n_b, style, $urandom_range(0, 7) != 0);
            random_items += n_a + n_b + 1;
        end
        s_tvalid <= 1'b0;

        // Let the checker see the last item, then drain every expected result.
        @(posedge i_clk);
        while (pending != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Covered %0d merge runs (%0d with dropped loads), %0d result items checked",
                 merges, overflow_merges, results);
        $display("Mismatches or stray results: %0d", errors);
        if (errors == 0 && pending == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

@@ two_way_sorted_merge_core.f @@
hw/rtl/tsm_pkg.sv
hw/rtl/two_way_sorted_merge_core.sv
verif/merge_order_checker.sv
verif/tb_two_way_sorted_merge_core.sv
